>>> hdl/fpst_pkg.sv
// Shared types, codes and constants of the prefix-sum tree block.
package fpst_pkg;

    localparam int POS_W       = 11;
    localparam int DATA_W      = 32;
    localparam int WALK_W      = POS_W + 1;
    localparam int ADDR_MAX_W  = 16;
    localparam int TREE_SIZE_DEFAULT = 1024;

    localparam logic [POS_W-1:0] ACTIVE_SIZE_RESET = POS_W'(1024);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] delta;
    } fpst_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] prefix_sum;
        logic              rejected;
    } fpst_out_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] addr;
        logic [DATA_W-1:0]     data;
    } fpst_wr_t;

    typedef struct packed {
        logic                  re;
        logic [ADDR_MAX_W-1:0] addr;
    } fpst_rd_t;

endpackage

>>> hdl/fpst_mem.sv
// Partial-sum store: one write port and one registered read port.
module fpst_mem
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEFAULT
) (
    input  logic              aclk,
    input  fpst_wr_t          wr,
    input  fpst_rd_t          rd,
    output logic [DATA_W-1:0] rdata
);

    localparam int AW = $clog2(TREE_SIZE);

    logic [DATA_W-1:0] mem [TREE_SIZE];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.re) begin
            rdata_reg <= mem[rd.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fpst_ctrl.sv
// Tree walk sequencer, clearing pass, size register and output register.
module fpst_ctrl
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [POS_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  fpst_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fpst_out_t         m_data,
    output fpst_wr_t          wr,
    output fpst_rd_t          rd,
    input  logic [DATA_W-1:0] rdata
);

    localparam int AW = $clog2(TREE_SIZE);
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam logic [WALK_W-1:0] SIZE_CAP =
        (TREE_SIZE > POS_MAX) ? WALK_W'(POS_MAX) : WALK_W'(TREE_SIZE);
    localparam logic [AW-1:0] CLR_LAST = AW'(TREE_SIZE - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [POS_W-1:0]  active_size_reg, active_size_next;
    logic [WALK_W-1:0] p_reg, p_next;
    logic [WALK_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_reg, pend_next;
    logic              op_reg, op_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              rej_reg, rej_next;
    logic              m_valid_reg, m_valid_next;
    fpst_out_t         m_data_reg, m_data_next;

    logic [WALK_W-1:0] lim;
    logic [WALK_W-1:0] pos_ext;
    logic [WALK_W-1:0] low_bit;
    logic [WALK_W-1:0] node_addr;
    logic              out_free;
    logic              issue;

    assign lim = ({1'b0, active_size_reg} < SIZE_CAP) ? {1'b0, active_size_reg} : SIZE_CAP;
    assign pos_ext   = {1'b0, s_data.position};
    assign low_bit   = p_reg & (~p_reg + WALK_W'(1));
    assign node_addr = p_reg - WALK_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign issue     = (p_reg != '0) && ((op_reg == OP_QUERY) || (p_reg <= lim));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        active_size_next = cfg_we ? cfg_wdata : active_size_reg;
        p_next           = p_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        op_next          = op_reg;
        delta_next       = delta_reg;
        acc_next         = acc_reg;
        rej_next         = rej_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        wr               = '0;
        rd               = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr.we    = 1'b1;
                wr.addr  = ADDR_MAX_W'(clr_reg);
                wr.data  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.operation;
                    delta_next = s_data.delta;
                    acc_next   = '0;
                    rej_next   = 1'b0;
                    pend_next  = 1'b0;
                    if (s_data.operation == OP_QUERY) begin
                        p_next     = (pos_ext > lim) ? lim : pos_ext;
                        state_next = ST_WALK;
                    end else if ((pos_ext == '0) || (pos_ext > lim)) begin
                        rej_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        p_next     = pos_ext;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (pend_reg) begin
                    if (op_reg == OP_QUERY) begin
                        acc_next = acc_reg + rdata;
                    end else begin
                        wr.we   = 1'b1;
                        wr.addr = ADDR_MAX_W'(pend_addr_reg);
                        wr.data = rdata + delta_reg;
                    end
                end
                if (issue) begin
                    rd.re          = 1'b1;
                    rd.addr        = ADDR_MAX_W'(node_addr);
                    pend_next      = 1'b1;
                    pend_addr_next = node_addr;
                    p_next = (op_reg == OP_QUERY) ? p_reg - low_bit : p_reg + low_bit;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (out_free) begin
                            m_valid_next           = 1'b1;
                            m_data_next.prefix_sum = acc_reg;
                            m_data_next.rejected   = rej_reg;
                            state_next             = ST_IDLE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.prefix_sum = acc_reg;
                    m_data_next.rejected   = rej_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            active_size_reg <= ACTIVE_SIZE_RESET;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            active_size_reg <= active_size_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg         <= p_next;
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        rej_reg       <= rej_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTH
    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.we && rd.re) |-> (wr.addr != rd.addr))
        else $error("write and read hit the same tree node");

    a_pend_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (pend_addr_reg < SIZE_CAP))
        else $error("pending read beyond the tree");

    a_reject_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.rejected && (m_data_reg.prefix_sum != '0)))
        else $error("rejected item carries a nonzero sum");

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && (op_reg == OP_ADD)) |-> (p_reg <= {lim[WALK_W-2:0], 1'b0}))
        else $error("update walk ran past twice the bound");
`endif

endmodule

>>> hdl/fenwick_prefix_sum_tree_top.sv
// Top level of the binary indexed prefix-sum tree.
//
//   channel   direction   ports                          payload
//   config    in          cfg_we, cfg_wdata              active_size
//   input     in          s_valid, s_ready, s_data       operation, position, delta
//   result    out         m_valid, m_ready, m_data       prefix_sum, rejected
//
// An item visits at most 11 tree nodes at 1024 positions, and the walk reads one node a cycle
// from the store; a query that visits none and a rejected update read no node at all.
// The input is ready again when the result shows, so no item is taken while a walk runs.
// After reset a clearing pass zeroes the store; no item is taken then.
// A stalled result waits in the output register; the next item may be accepted meanwhile.
module fenwick_prefix_sum_tree_top
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  fpst_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fpst_out_t        m_data
);

    fpst_wr_t          wr;
    fpst_rd_t          rd;
    logic [DATA_W-1:0] rdata;

    fpst_ctrl #(
        .TREE_SIZE(TREE_SIZE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .wr        (wr),
        .rd        (rd),
        .rdata     (rdata)
    );

    fpst_mem #(
        .TREE_SIZE(TREE_SIZE)
    ) u_mem (
        .aclk  (aclk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

endmodule

>>> dv/fpst_checker.sv
// Checker for the prefix-sum tree: follows both channels, predicts each result and compares.
`timescale 1ns / 100ps
module fpst_checker
    import fpst_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  fpst_in_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  fpst_out_t        m_data,
    output int               in_flight,
    output int               error_count
);

    logic [DATA_W-1:0] node_sum [TREE_SIZE];
    logic [POS_W-1:0]  size_reg;
    fpst_out_t         pending_results [$];

    function automatic int unsigned walk_bound();
        return (int'(size_reg) < TREE_SIZE) ? int'(size_reg) : TREE_SIZE;
    endfunction

    function automatic fpst_out_t tree_step(fpst_in_t it);
        fpst_out_t         res;
        int unsigned       p;
        int unsigned       lim;
        logic [DATA_W-1:0] acc;
        res = '0;
        lim = walk_bound();
        p   = 32'(it.position);
        if (it.operation == OP_QUERY) begin
            acc = '0;
            if (p > lim) begin
                p = lim;
            end
            while (p != 0) begin
                acc += node_sum[p-1];
                p   -= p & (~p + 1);
            end
            res.prefix_sum = acc;
        end else if (p == 0 || p > lim) begin
            res.rejected = 1'b1;
        end else begin
            while (p <= lim) begin
                node_sum[p-1] += it.delta;
                p             += p & (~p + 1);
            end
        end
        return res;
    endfunction

    task automatic report(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin : monitor
        fpst_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < TREE_SIZE; i++) begin
                node_sum[i] = '0;
            end
            size_reg = ACTIVE_SIZE_RESET;
            pending_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(tree_step(s_data));
            end
            if (cfg_we) begin
                size_reg = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report($sformatf("result %h with no item outstanding", m_data));
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.prefix_sum !== want.prefix_sum) begin
                        report($sformatf("prefix_sum got %h, expected %h",
                                         m_data.prefix_sum, want.prefix_sum));
                    end
                    if (m_data.rejected !== want.rejected) begin
                        report($sformatf("rejected got %b, expected %b",
                                         m_data.rejected, want.rejected));
                    end
                end
            end
        end
        in_flight <= pending_results.size();
    end

endmodule

>>> dv/tb_fenwick_prefix_sum_tree_top.sv
// Testbench top for the prefix-sum tree: stimulus, flow control and the final verdict.
`timescale 1ns / 100ps
module tb_fenwick_prefix_sum_tree_top;
    import fpst_pkg::*;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [POS_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    fpst_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    fpst_out_t        m_data;

    int               in_flight;
    int               error_count;

    int unsigned      send_idle_pct = 8;
    int unsigned      recv_idle_pct = 77;
    int unsigned      stall_cycles  = 0;
    int unsigned      cur_size      = 1024;
    int               items_sent    = 0;
    int               queries_sent  = 0;
    int               settings_used = 0;

    fenwick_prefix_sum_tree_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    fpst_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .in_flight   (in_flight),
        .error_count (error_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (stall_cycles > 0) begin
                m_ready <= 1'b0;
                stall_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer(fpst_in_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.operation == OP_QUERY) begin
            queries_sent++;
        end
    endtask

    task automatic offer_op(logic op, int unsigned pos, logic [DATA_W-1:0] d);
        fpst_in_t it;
        it.operation = op;
        it.position  = POS_W'(pos);
        it.delta     = d;
        offer(it);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
    endtask

    task automatic set_active_size(int unsigned v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= POS_W'(v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_size   = v;
        settings_used++;
    endtask

    function automatic fpst_in_t random_item(int unsigned size);
        fpst_in_t    it;
        int unsigned lim;
        int unsigned sel;
        lim = (size < TREE_SIZE_DEFAULT) ? size : TREE_SIZE_DEFAULT;
        it.operation = $urandom_range(0, 1) ? OP_QUERY : OP_ADD;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            it.position = '0;
        end else if (sel < 20 || lim == 0) begin
            it.position = POS_W'($urandom);
        end else if (sel < 28) begin
            it.position = POS_W'(lim);
        end else if (sel < 32) begin
            it.position = POS_W'(lim + 1);
        end else begin
            it.position = POS_W'($urandom_range(1, lim));
        end
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            it.delta = 32'h7fff_ffff;
        end else if (sel < 6) begin
            it.delta = 32'h8000_0000;
        end else if (sel < 9) begin
            it.delta = 32'hffff_ffff;
        end else if (sel < 50) begin
            it.delta = DATA_W'($urandom_range(0, 200) - 100);
        end else begin
            it.delta = $urandom;
        end
        return it;
    endfunction

    initial begin
        int unsigned seg_size;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        offer_op(OP_ADD,   1,    32'h7fff_ffff);
        offer_op(OP_ADD,   1024, 32'h8000_0000);
        offer_op(OP_ADD,   0,    32'h0000_0005);
        offer_op(OP_ADD,   1025, 32'h0000_0007);
        offer_op(OP_ADD,   2047, 32'hffff_ffff);
        offer_op(OP_ADD,   512,  32'hffff_ffff);
        offer_op(OP_ADD,   1023, 32'h0000_0001);
        offer_op(OP_QUERY, 0,    32'hffff_ffff);
        offer_op(OP_QUERY, 1,    32'h0000_0000);
        offer_op(OP_QUERY, 511,  32'h0000_0000);
        offer_op(OP_QUERY, 1023, 32'h0000_0000);
        offer_op(OP_QUERY, 1024, 32'h0000_0000);
        offer_op(OP_QUERY, 2047, 32'h0000_0000);
        set_active_size(5);
        offer_op(OP_ADD,   5,    32'h0000_0003);
        offer_op(OP_ADD,   6,    32'h0000_0001);
        offer_op(OP_QUERY, 2047, 32'h0000_0000);
        offer_op(OP_QUERY, 1024, 32'h0000_0000);
        set_active_size(0);
        offer_op(OP_ADD,   1,    32'h0000_0001);
        offer_op(OP_QUERY, 1,    32'h0000_0000);
        offer_op(OP_QUERY, 2047, 32'h0000_0000);
        set_active_size(2047);
        offer_op(OP_ADD,   1024, 32'h5555_5555);
        offer_op(OP_ADD,   1025, 32'h0000_0001);
        offer_op(OP_QUERY, 2047, 32'h0000_0000);
        offer_op(OP_QUERY, 1024, 32'h1234_5678);
        offer_op(OP_ADD,   1,    32'haaaa_aaaa);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: seg_size = 1024;
                1: seg_size = 1;
                2: seg_size = 700;
                3: seg_size = 0;
                4: seg_size = 2047;
                default: seg_size = $urandom_range(1, 1024);
            endcase
            set_active_size(seg_size);
            if (seg < 2) begin
                send_idle_pct = 8;
                recv_idle_pct = 77;
            end else if (seg < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 0) begin
                stall_cycles = 400;
            end
            repeat (310) offer(random_item(cur_size));
        end

        drain_results();
        repeat (16) @(posedge aclk);
        $display("Run covered %0d items (%0d queries, %0d updates) over %0d size settings,",
                 items_sent, queries_sent, items_sent - queries_sent, settings_used);
        $display("three flow-control regimes and one long output stall.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
